// ===== design/lgen_pkg.sv =====
// Shared types and constants of the toroidal life generation block.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package lgen_pkg;

  localparam int CFG_W = 9;

  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_GEN    = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_GEN  = 1'b1;

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  localparam logic [CFG_W-1:0] ROWS_RST = 9'd140;
  localparam logic [CFG_W-1:0] COLS_RST = 9'd217;

  // one column of the three-row window held by a cell
  typedef struct packed {
    logic up;
    logic mid;
    logic dn;
  } lgen_col_t;

endpackage

// ===== design/lgen_cell.sv =====
// One column cell: holds the three-row window of its column and forms the new bit.
// Depends on lgen_pkg.
`timescale 1ns / 1ps

module lgen_cell (
  input  logic                clk,
  input  logic                load,
  input  logic                shift_in,
  input  logic                in_use,
  input  lgen_pkg::lgen_col_t left_col,
  input  lgen_pkg::lgen_col_t right_col,
  output lgen_pkg::lgen_col_t col,
  output logic                new_bit
);
  import lgen_pkg::*;

  lgen_col_t col_r;
  logic [3:0] cnt;
  logic       live;

  always_ff @(posedge clk) begin
    if (load) begin
      col_r.up  <= col_r.mid;
      col_r.mid <= col_r.dn;
      col_r.dn  <= shift_in;
    end
  end

  always_comb begin
    cnt = {3'b0, left_col.up} + {3'b0, left_col.mid} + {3'b0, left_col.dn}
        + {3'b0, col_r.up} + {3'b0, col_r.dn}
        + {3'b0, right_col.up} + {3'b0, right_col.mid} + {3'b0, right_col.dn};
    if (col_r.mid) begin
      live = (cnt == 4'd2) || (cnt == 4'd3);
    end else begin
      live = (cnt == 4'd3);
    end
    new_bit = in_use ? live : col_r.mid;
  end

  assign col = col_r;

endmodule

// ===== design/lgen_row.sv =====
// Chain of column cells with horizontal wrap at the column count in use.
// Depends on lgen_pkg and lgen_cell.
`timescale 1ns / 1ps

module lgen_row #(
  parameter int MAX_COLS = 256
) (
  input  logic                          clk,
  input  logic                          load,
  input  logic [MAX_COLS-1:0]           row_in,
  input  logic [$clog2(MAX_COLS+1)-1:0] nc,
  output logic [MAX_COLS-1:0]           row_out
);
  import lgen_pkg::*;

  localparam int CW     = $clog2(MAX_COLS);
  localparam int CCNT_W = $clog2(MAX_COLS+1);

  lgen_col_t        cols   [MAX_COLS];
  lgen_col_t        lefts  [MAX_COLS];
  lgen_col_t        rights [MAX_COLS];
  logic [CW-1:0]    last_ix;

  assign last_ix = CW'(nc - CCNT_W'(1));

  for (genvar j = 0; j < MAX_COLS; j++) begin : g_cell
    if (j == 0) begin : g_first
      assign lefts[j] = cols[last_ix];
    end else begin : g_inner
      assign lefts[j] = cols[j-1];
    end
    if (j == MAX_COLS-1) begin : g_end
      assign rights[j] = cols[0];
    end else begin : g_mid
      assign rights[j] = (CCNT_W'(j+1) == nc) ? cols[0] : cols[j+1];
    end

    lgen_cell u_cell (
      .clk      (clk),
      .load     (load),
      .shift_in (row_in[j]),
      .in_use   (nc > CCNT_W'(j)),
      .left_col (lefts[j]),
      .right_col(rights[j]),
      .col      (cols[j]),
      .new_bit  (row_out[j])
    );
  end

endmodule

// ===== design/life_toroidal_generation.sv =====
// Top level of the toroidal life generation block: grid stores, sequencer, ports.
// Depends on lgen_pkg and lgen_row.
//
//  channel  dir  handshake          contents
//  in_      in   tvalid/tready      tuser: op; tdata: row, col, cell_in
//  out_     out  tvalid/tready      tuser: kind; tdata: cell_out
//  cfg_     in   cfg_we             cfg_addr selects rows_used / cols_used
//
// Write and read beats pass through the access state S_ACC; a generation's length is set
// by the single read port of the grid store (three row reads per row),
// then one write and a copy back of each row.
// After reset a clearing pass zeroes every row of the grid; no beat is taken.
// Reset is synchronous, active low. A result waiting on out_ holds the next
// read or generation in its final cycle; writes go on.
`timescale 1ns / 1ps

module life_toroidal_generation #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 256
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [23:0]               in_tdata,   // row[7:0], col[15:8], cell_in[16]
  input  logic [1:0]                in_tuser,   // op[1:0]
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [7:0]                out_tdata,  // cell_out[0]
  output logic                      out_tuser,  // kind[0]
  input  logic                      cfg_we,
  input  logic                      cfg_addr,
  input  logic [lgen_pkg::CFG_W-1:0] cfg_wdata
);
  import lgen_pkg::*;

  localparam int RW     = $clog2(MAX_ROWS);
  localparam int CW     = $clog2(MAX_COLS);
  localparam int RCNT_W = $clog2(MAX_ROWS+1);
  localparam int CCNT_W = $clog2(MAX_COLS+1);
  localparam int RCMP_W = (RCNT_W > CFG_W) ? RCNT_W : CFG_W;
  localparam int CCMP_W = (CCNT_W > CFG_W) ? CCNT_W : CFG_W;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_ACC, S_GA, S_GB, S_GC, S_GD, S_GE, S_CA, S_CB, S_GDONE
  } state_t;

  state_t           state_r, state_nxt;
  logic [RW-1:0]    i_r, i_nxt;
  logic [1:0]       op_r, op_nxt;
  logic [7:0]       row_r, row_nxt;
  logic [7:0]       col_r, col_nxt;
  logic             val_r, val_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_kind_r, out_kind_nxt;
  logic             out_cell_r, out_cell_nxt;
  logic [CFG_W-1:0] rows_used_r, cols_used_r;

  logic [MAX_COLS-1:0] grid_mem [MAX_ROWS];
  logic [MAX_COLS-1:0] next_mem [MAX_ROWS];
  logic [MAX_COLS-1:0] grid_q, next_q, grid_wd, new_row, rmw_row;
  logic [RW-1:0]       grid_ra, grid_wa;
  logic                grid_we, next_we, row_load;

  logic [RCNT_W-1:0] nr;
  logic [CCNT_W-1:0] nc;
  logic [RCMP_W-1:0] rows_ext;
  logic [CCMP_W-1:0] cols_ext;
  logic              in_bounds, last_row, slot_free;
  logic [RW-1:0]     up_ix, dn_ix, in_row_ix, row_ix;
  logic [CW-1:0]     col_ix;

  // sizes in use
  always_comb begin
    rows_ext = RCMP_W'(rows_used_r);
    cols_ext = CCMP_W'(cols_used_r);
    if (rows_ext == '0) begin
      nr = RCNT_W'(1);
    end else if (rows_ext > RCMP_W'(MAX_ROWS)) begin
      nr = RCNT_W'(MAX_ROWS);
    end else begin
      nr = RCNT_W'(rows_ext);
    end
    if (cols_ext == '0) begin
      nc = CCNT_W'(1);
    end else if (cols_ext > CCMP_W'(MAX_COLS)) begin
      nc = CCNT_W'(MAX_COLS);
    end else begin
      nc = CCNT_W'(cols_ext);
    end
  end

  assign in_bounds = (RCMP_W'(row_r) < RCMP_W'(nr)) && (CCMP_W'(col_r) < CCMP_W'(nc));
  assign row_ix    = RW'(row_r);
  assign col_ix    = CW'(col_r);
  assign in_row_ix = RW'(in_tdata[7:0]);
  assign last_row  = (RCMP_W'(i_r) + RCMP_W'(1)) == RCMP_W'(nr);
  assign up_ix     = (i_r == '0) ? RW'(nr - RCNT_W'(1)) : i_r - RW'(1);
  assign dn_ix     = last_row ? '0 : i_r + RW'(1);
  assign slot_free = !out_valid_r || out_tready;

  always_comb begin
    rmw_row         = grid_q;
    rmw_row[col_ix] = val_r;
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_used_r <= ROWS_RST;
      cols_used_r <= COLS_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_ROWS: rows_used_r <= cfg_wdata;
        REG_COLS: cols_used_r <= cfg_wdata;
        default:  rows_used_r <= rows_used_r;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    op_nxt        = op_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    val_nxt       = val_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_cell_nxt  = out_cell_r;
    in_tready     = 1'b0;
    grid_ra       = row_ix;
    grid_we       = 1'b0;
    grid_wa       = i_r;
    grid_wd       = next_q;
    next_we       = 1'b0;
    row_load      = 1'b0;
    case (state_r)
      S_CLR: begin
        grid_we = 1'b1;
        grid_wd = '0;
        i_nxt   = i_r + RW'(1);
        if (i_r == RW'(MAX_ROWS-1)) begin
          i_nxt     = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        grid_ra   = in_row_ix;
        if (in_tvalid) begin
          op_nxt  = in_tuser;
          row_nxt = in_tdata[7:0];
          col_nxt = in_tdata[15:8];
          val_nxt = in_tdata[16];
          i_nxt   = '0;
          case (in_tuser)
            OP_WRITE: state_nxt = S_ACC;
            OP_READ:  state_nxt = S_ACC;
            OP_GEN:   state_nxt = S_GA;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end
      S_ACC: begin
        if (op_r == OP_WRITE) begin
          grid_we   = in_bounds;
          grid_wa   = row_ix;
          grid_wd   = rmw_row;
          state_nxt = S_IDLE;
        end else if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_READ;
          out_cell_nxt  = in_bounds && grid_q[col_ix];
          state_nxt     = S_IDLE;
        end
      end
      S_GA: begin
        grid_ra   = up_ix;
        state_nxt = S_GB;
      end
      S_GB: begin
        grid_ra   = i_r;
        row_load  = 1'b1;
        state_nxt = S_GC;
      end
      S_GC: begin
        grid_ra   = dn_ix;
        row_load  = 1'b1;
        state_nxt = S_GD;
      end
      S_GD: begin
        row_load  = 1'b1;
        state_nxt = S_GE;
      end
      S_GE: begin
        next_we = 1'b1;
        if (last_row) begin
          i_nxt     = '0;
          state_nxt = S_CA;
        end else begin
          i_nxt     = i_r + RW'(1);
          state_nxt = S_GA;
        end
      end
      S_CA: begin
        state_nxt = S_CB;
      end
      S_CB: begin
        grid_we = 1'b1;
        if (last_row) begin
          state_nxt = S_GDONE;
        end else begin
          i_nxt     = i_r + RW'(1);
          state_nxt = S_CA;
        end
      end
      S_GDONE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_GEN;
          out_cell_nxt  = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      i_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r       <= op_nxt;
    row_r      <= row_nxt;
    col_r      <= col_nxt;
    val_r      <= val_nxt;
    out_kind_r <= out_kind_nxt;
    out_cell_r <= out_cell_nxt;
  end

  // grid stores
  always_ff @(posedge clk) begin
    if (grid_we) begin
      grid_mem[grid_wa] <= grid_wd;
    end
    grid_q <= grid_mem[grid_ra];
  end

  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem[i_r] <= new_row;
    end
    next_q <= next_mem[i_r];
  end

  lgen_row #(
    .MAX_COLS(MAX_COLS)
  ) u_row (
    .clk    (clk),
    .load   (row_load),
    .row_in (grid_q),
    .nc     (nc),
    .row_out(new_row)
  );

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {7'b0, out_cell_r};

`ifndef SYNTHESIS
  a_grid_we_phase: assert property (@(posedge clk) disable iff (!rst_n)
    grid_we |-> (state_r == S_CLR || state_r == S_ACC || state_r == S_CB))
    else $error("grid written outside clear, access or copy");

  a_next_we_phase: assert property (@(posedge clk) disable iff (!rst_n)
    next_we |-> (state_r == S_GE))
    else $error("next grid written outside compute");

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GE || state_r == S_CB) |-> (RCMP_W'(i_r) < RCMP_W'(nr)))
    else $error("generation row beyond rows in use");

  a_gen_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GDONE && slot_free) |=> (out_valid_r && out_kind_r == KIND_GEN))
    else $error("generation result not presented");
`endif

endmodule

// ===== dv/testbench.sv =====
// Self-checking bench for the toroidal life generation block: cell writes, reads and
// generations over several grid sizes, with random gaps and stalls on both channels.
// Depends on lgen_pkg and life_toroidal_generation.
`timescale 1ns / 1ps

module testbench;
  import lgen_pkg::*;

  typedef struct {
    logic [1:0] op;
    logic [7:0] row;
    logic [7:0] col;
    logic       cell_val;
  } cell_cmd_t;

  typedef struct {
    logic kind;
    logic cell_val;
  } cell_resp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [23:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic out_tuser;
  logic cfg_we = 1'b0;
  logic cfg_addr = REG_ROWS;
  logic [CFG_W-1:0] cfg_wdata = '0;

  cell_cmd_t  pending_cmds[$];
  cell_resp_t awaited_resps[$];
  bit         life_grid[256][256];
  bit         next_life[256][256];
  logic [CFG_W-1:0] rows_reg = ROWS_RST;
  logic [CFG_W-1:0] cols_reg = COLS_RST;
  int  fail_count = 0;
  int  cycle_count = 0;
  int  send_gap = 0;
  int  recv_stall = 0;
  bit  calm = 1'b0;

  always #4 clk = ~clk;

  life_toroidal_generation u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  function automatic int eff_size(logic [CFG_W-1:0] r);
    if (r == 0) return 1;
    if (r > 256) return 256;
    return int'(r);
  endfunction

  function automatic int draw_wait();
    return calm ? 0 : $urandom_range(0, 13);
  endfunction

  task automatic step_life();
    int nr, nc, up, dn, lf, rt, n;
    nr = eff_size(rows_reg);
    nc = eff_size(cols_reg);
    for (int i = 0; i < nr; i++) begin
      up = (i == 0) ? nr - 1 : i - 1;
      dn = (i + 1 == nr) ? 0 : i + 1;
      for (int j = 0; j < nc; j++) begin
        lf = (j == 0) ? nc - 1 : j - 1;
        rt = (j + 1 == nc) ? 0 : j + 1;
        n = life_grid[up][lf] + life_grid[up][j] + life_grid[up][rt]
          + life_grid[i][lf] + life_grid[i][rt]
          + life_grid[dn][lf] + life_grid[dn][j] + life_grid[dn][rt];
        next_life[i][j] = life_grid[i][j] ? (n == 2 || n == 3) : (n == 3);
      end
    end
    for (int i = 0; i < nr; i++)
      for (int j = 0; j < nc; j++)
        life_grid[i][j] = next_life[i][j];
  endtask

  task automatic predict_cmd(cell_cmd_t c);
    bit inside_sz;
    cell_resp_t r;
    inside_sz = (int'(c.row) < eff_size(rows_reg)) && (int'(c.col) < eff_size(cols_reg));
    case (c.op)
      OP_WRITE: begin
        if (inside_sz) life_grid[c.row][c.col] = c.cell_val;
      end
      OP_READ: begin
        r.kind = KIND_READ;
        r.cell_val = inside_sz ? life_grid[c.row][c.col] : 1'b0;
        awaited_resps.push_back(r);
      end
      OP_GEN: begin
        step_life();
        r.kind = KIND_GEN;
        r.cell_val = 1'b0;
        awaited_resps.push_back(r);
      end
      default: ;
    endcase
  endtask

  // driver
  always @(posedge clk) begin
    cell_cmd_t c;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        c.op = in_tuser;
        c.row = in_tdata[7:0];
        c.col = in_tdata[15:8];
        c.cell_val = in_tdata[16];
        predict_cmd(c);
      end
      if (!(in_tvalid && !in_tready)) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_tvalid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          c = pending_cmds.pop_front();
          in_tuser <= c.op;
          in_tdata <= {7'd0, c.cell_val, c.col, c.row};
          in_tvalid <= 1'b1;
          send_gap <= draw_wait();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cell_resp_t e;
    int s;
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_stall <= 0;
    end else if (out_tvalid && out_tready) begin
      if (awaited_resps.size() == 0) begin
        $error("unexpected beat kind=%0d data=%0h", out_tuser, out_tdata);
        fail_count++;
      end else begin
        e = awaited_resps.pop_front();
        if (out_tuser !== e.kind) begin
          $error("kind: expected %0d actual %0d", e.kind, out_tuser);
          fail_count++;
        end
        if (out_tdata !== {7'd0, e.cell_val}) begin
          $error("cell_out: expected %0h actual %0h", {7'd0, e.cell_val}, out_tdata);
          fail_count++;
        end
      end
      s = draw_wait();
      recv_stall <= s;
      out_tready <= (s == 0);
    end else if (recv_stall > 0) begin
      recv_stall <= recv_stall - 1;
      out_tready <= (recv_stall == 1);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2000000) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic push_cmd(logic [1:0] op, int row, int col, bit cell_val);
    cell_cmd_t c;
    c.op = op;
    c.row = row[7:0];
    c.col = col[7:0];
    c.cell_val = cell_val;
    pending_cmds.push_back(c);
  endtask

  task automatic settle();
    while (pending_cmds.size() > 0 || in_tvalid || awaited_resps.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_size(logic [CFG_W-1:0] r, logic [CFG_W-1:0] c);
    settle();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= REG_ROWS;
    cfg_wdata <= r;
    rows_reg = r;
    @(posedge clk);
    cfg_addr <= REG_COLS;
    cfg_wdata <= c;
    cols_reg = c;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_burst(int count, int gen_pct);
    int nr, nc, k, row, col;
    logic [1:0] op;
    nr = eff_size(rows_reg);
    nc = eff_size(cols_reg);
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 99);
      if (k < gen_pct) op = OP_GEN;
      else if (k < gen_pct + 3) op = OP_UNUSED;
      else if (k < 60) op = OP_WRITE;
      else op = OP_READ;
      row = ($urandom_range(0, 99) < 85) ? $urandom_range(0, nr - 1) : $urandom_range(0, 255);
      col = ($urandom_range(0, 99) < 85) ? $urandom_range(0, nc - 1) : $urandom_range(0, 255);
      push_cmd(op, row, col, $urandom_range(0, 1));
    end
  endtask

  initial begin
    int r, c;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset size, edges, outside accesses, unused op, a generation
    calm = 1'b1;
    push_cmd(OP_READ, 0, 0, 0);
    push_cmd(OP_WRITE, 0, 0, 1);
    push_cmd(OP_WRITE, 139, 216, 1);
    push_cmd(OP_WRITE, 140, 0, 1);
    push_cmd(OP_WRITE, 0, 217, 1);
    push_cmd(OP_WRITE, 255, 255, 1);
    push_cmd(OP_READ, 0, 0, 0);
    push_cmd(OP_READ, 139, 216, 0);
    push_cmd(OP_READ, 140, 0, 0);
    push_cmd(OP_READ, 255, 255, 0);
    push_cmd(OP_UNUSED, 5, 5, 1);
    push_cmd(OP_GEN, 0, 0, 0);
    push_cmd(OP_READ, 0, 0, 0);
    push_cmd(OP_READ, 139, 0, 0);

    // blinker on a 5x5 torus, stepped twice, then a read outside the grid
    set_size(9'd5, 9'd5);
    calm = 1'b0;
    push_cmd(OP_WRITE, 0, 0, 0);
    push_cmd(OP_WRITE, 139 % 5, 216 % 5, 0);
    push_cmd(OP_WRITE, 2, 1, 1);
    push_cmd(OP_WRITE, 2, 2, 1);
    push_cmd(OP_WRITE, 2, 3, 1);
    push_cmd(OP_GEN, 0, 0, 0);
    push_cmd(OP_READ, 1, 2, 0);
    push_cmd(OP_READ, 2, 1, 0);
    push_cmd(OP_GEN, 0, 0, 0);
    push_cmd(OP_READ, 2, 3, 0);
    push_cmd(OP_READ, 5, 0, 0);

    // extremes of both registers
    set_size(9'd0, 9'd0);
    random_burst(6, 20);
    set_size(9'd1, 9'd2);
    random_burst(8, 20);
    set_size(9'd2, 9'd1);
    random_burst(8, 20);
    set_size(9'd511, 9'd256);
    random_burst(10, 0);
    push_cmd(OP_WRITE, 255, 0, 1);
    push_cmd(OP_WRITE, 0, 255, 1);
    push_cmd(OP_WRITE, 0, 0, 1);
    push_cmd(OP_GEN, 0, 0, 0);
    push_cmd(OP_READ, 255, 255, 0);
    set_size(9'd256, 9'd511);
    random_burst(6, 0);
    set_size(9'd3, 9'd255);
    random_burst(8, 10);

    // random sizes, mostly small
    for (int p = 0; p < 9; p++) begin
      r = $urandom_range(0, 99) < 80 ? $urandom_range(1, 12) : $urandom_range(0, 511);
      c = $urandom_range(0, 99) < 80 ? $urandom_range(1, 12) : $urandom_range(0, 511);
      set_size(r[CFG_W-1:0], c[CFG_W-1:0]);
      calm = (p % 3 == 2);
      random_burst(3, 12);
    end

    settle();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/lgen_pkg.sv
design/lgen_cell.sv
design/lgen_row.sv
design/life_toroidal_generation.sv
dv/testbench.sv
